>>> rtl/core/indexed_list_table_top_macros.svh
// ----------------------------------------------------------------------------
// indexed_list_table_top_macros.svh
// Assertion macros for the indexed list table. Assertions are compiled in
// simulation and drop out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_TABLE_TOP_MACROS_SVH
`define INDEXED_LIST_TABLE_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset
`define ILT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("indexed list table: same-cycle check failed");
// Next-cycle implication, checked out of reset
`define ILT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("indexed list table: next-cycle check failed");
`else
`define ILT_ASSERT_NOW(lbl, ante, cons)
`define ILT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> rtl/core/ilt_pkg.sv
// ----------------------------------------------------------------------------
// ilt_pkg
// Shared constants, codes and types of the indexed list table.
// ----------------------------------------------------------------------------
package ilt_pkg;

  // Capacity and widths
  localparam int DEPTH   = 64;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = 7;
  localparam int POS_W   = 7;
  localparam int DATA_W  = 32;
  localparam int MODE_W  = 3;
  localparam int STAT_W  = 2;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_APPEND = 3'd0;
  localparam logic [MODE_W-1:0] MODE_READ   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FIND   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_INSERT = 3'd3;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd4;

  // Result status
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  // Find miss marker
  localparam logic [POS_W-1:0] NOT_FOUND = 7'h7F;

  // Operation broadcast to every cell (only checked, legal operations set)
  typedef struct packed {
    logic              en;
    logic              app;
    logic              ins;
    logic              rem;
    logic              fnd;
    logic              rd;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] value;
    logic [CNT_W-1:0]  count;
  } op_t;

endpackage

>>> rtl/core/ilt_cell.sv
// ----------------------------------------------------------------------------
// ilt_cell
// One list slot: holds an element, takes a neighbor's element on insert or
// remove, and flags a find match or a read select for the result stage.
// ----------------------------------------------------------------------------
module ilt_cell (
  input  logic                       clk,
  input  logic [ilt_pkg::IDX_W-1:0]  idx,
  input  ilt_pkg::op_t               op,
  input  logic [ilt_pkg::DATA_W-1:0] left_data,
  input  logic [ilt_pkg::DATA_W-1:0] right_data,
  output logic [ilt_pkg::DATA_W-1:0] data,
  output logic                       hit
);

  logic [ilt_pkg::DATA_W-1:0] data_r, data_nxt;
  logic                       hit_r, hit_nxt;
  logic [ilt_pkg::POS_W-1:0]  my_pos;
  logic                       below_cnt;

  assign my_pos    = {{(ilt_pkg::POS_W - ilt_pkg::IDX_W){1'b0}}, idx};
  assign below_cnt = my_pos < op.count;

  // Element update: load at the end, shift up on insert, shift down on remove
  always_comb begin
    data_nxt = data_r;
    if (op.app && (my_pos == op.count)) begin
      data_nxt = op.value;
    end else if (op.ins) begin
      if (my_pos == op.pos) begin
        data_nxt = op.value;
      end else if (my_pos > op.pos) begin
        data_nxt = left_data;
      end
    end else if (op.rem && (my_pos >= op.pos)) begin
      data_nxt = right_data;
    end
  end

  // Match flag, taken from the element before this request's update
  always_comb begin
    hit_nxt = (op.fnd && (data_r == op.value) && below_cnt) ||
              (op.rd && (my_pos == op.pos) && below_cnt);
  end

  always_ff @(posedge clk) begin
    if (op.en) begin
      data_r <= data_nxt;
      hit_r  <= hit_nxt;
    end
  end

  assign data = data_r;
  assign hit  = hit_r;

endmodule

>>> rtl/core/indexed_list_table_top.sv
// ----------------------------------------------------------------------------
// indexed_list_table_top
// Bounded ordered list of signed 32-bit values held in a chain of cells.
// Requests are registered in the cells and pending stage, responses in out regs.
// Throughput: one request per cycle; a stalled response holds stage two and
// stalls the input. Reset (rst_n low) clears count and handshake state only.
// ----------------------------------------------------------------------------
`include "indexed_list_table_top_macros.svh"

module indexed_list_table_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ilt_pkg::MODE_W-1:0]        in_mode,
  input  logic [ilt_pkg::POS_W-1:0]         in_position,
  input  logic signed [ilt_pkg::DATA_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [ilt_pkg::DATA_W-1:0] out_read_value,
  output logic signed [ilt_pkg::POS_W-1:0]  out_found_index,
  output logic [ilt_pkg::CNT_W-1:0]         out_count,
  output logic [ilt_pkg::STAT_W-1:0]        out_status
);

  logic                        in_acc;
  logic                        load_out;
  ilt_pkg::op_t                op;
  logic [ilt_pkg::STAT_W-1:0]  st;
  logic [ilt_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;

  logic                        pend_r;
  logic                        p_find_r;
  logic [ilt_pkg::STAT_W-1:0]  p_status_r;
  logic [ilt_pkg::CNT_W-1:0]   p_count_r;

  logic                        out_valid_r;
  logic [ilt_pkg::DATA_W-1:0]  out_read_value_r;
  logic [ilt_pkg::POS_W-1:0]   out_found_index_r;
  logic [ilt_pkg::CNT_W-1:0]   out_count_r;
  logic [ilt_pkg::STAT_W-1:0]  out_status_r;

  logic [ilt_pkg::DATA_W-1:0]  cell_data [ilt_pkg::DEPTH];
  logic [ilt_pkg::DEPTH-1:0]   hits;
  logic [ilt_pkg::DEPTH-1:0]   low_hit;
  logic [ilt_pkg::IDX_W-1:0]   enc;
  logic [ilt_pkg::DATA_W-1:0]  rd_sel;
  logic [ilt_pkg::POS_W-1:0]   found_val;

  logic                        acc_app_ok;
  logic                        acc_lookup;

  // Handshake: second stage drains into the output register
  assign load_out = pend_r && (!out_valid_r || !out_stall);
  assign in_stall = !rst_n || (pend_r && !load_out);
  assign in_acc   = in_valid && !in_stall;

  // Request decode and range / capacity checks
  always_comb begin
    op       = '0;
    st       = ilt_pkg::ST_OK;
    cnt_nxt  = cnt_r;
    op.en    = in_acc;
    op.pos   = in_position;
    op.value = in_value;
    op.count = cnt_r;
    if (in_acc) begin
      unique case (in_mode)
        ilt_pkg::MODE_APPEND: begin
          if (cnt_r == ilt_pkg::CNT_W'(ilt_pkg::DEPTH)) begin
            st = ilt_pkg::ST_FULL;
          end else begin
            op.app  = 1'b1;
            cnt_nxt = cnt_r + ilt_pkg::CNT_W'(1);
          end
        end
        ilt_pkg::MODE_READ: begin
          if (in_position >= cnt_r) begin
            st = ilt_pkg::ST_RANGE;
          end else begin
            op.rd = 1'b1;
          end
        end
        ilt_pkg::MODE_FIND: begin
          op.fnd = 1'b1;
        end
        ilt_pkg::MODE_INSERT: begin
          if (in_position > cnt_r) begin
            st = ilt_pkg::ST_RANGE;
          end else if (cnt_r == ilt_pkg::CNT_W'(ilt_pkg::DEPTH)) begin
            st = ilt_pkg::ST_FULL;
          end else begin
            op.ins  = 1'b1;
            cnt_nxt = cnt_r + ilt_pkg::CNT_W'(1);
          end
        end
        ilt_pkg::MODE_REMOVE: begin
          if (in_position >= cnt_r) begin
            st = ilt_pkg::ST_RANGE;
          end else begin
            op.rem  = 1'b1;
            cnt_nxt = cnt_r - ilt_pkg::CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Cell chain
  for (genvar i = 0; i < ilt_pkg::DEPTH; i++) begin : g_cell
    logic [ilt_pkg::DATA_W-1:0] left_d, right_d;
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_left
      assign left_d = cell_data[i-1];
    end
    if (i == ilt_pkg::DEPTH - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_right
      assign right_d = cell_data[i+1];
    end
    ilt_cell u_cell (
      .clk        (clk),
      .idx        (ilt_pkg::IDX_W'(i)),
      .op         (op),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[i]),
      .hit        (hits[i])
    );
  end

  // Result stage: lowest match index and read select (hits are one-hot on read)
  assign low_hit = hits & (~hits + ilt_pkg::DEPTH'(1));

  always_comb begin
    enc    = '0;
    rd_sel = '0;
    for (int i = 0; i < ilt_pkg::DEPTH; i++) begin
      if (low_hit[i]) begin
        enc = enc | ilt_pkg::IDX_W'(i);
      end
      rd_sel = rd_sel | ({ilt_pkg::DATA_W{hits[i]}} & cell_data[i]);
    end
  end

  always_comb begin
    found_val = '0;
    if (p_find_r) begin
      found_val = (|hits) ? {{(ilt_pkg::POS_W - ilt_pkg::IDX_W){1'b0}}, enc}
                          : ilt_pkg::NOT_FOUND;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_acc) begin
        pend_r <= 1'b1;
      end else if (load_out) begin
        pend_r <= 1'b0;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers; find hits never feed the read value
  always_ff @(posedge clk) begin
    if (in_acc) begin
      p_find_r   <= (in_mode == ilt_pkg::MODE_FIND);
      p_status_r <= st;
      p_count_r  <= cnt_nxt;
    end
    if (load_out) begin
      out_read_value_r  <= p_find_r ? '0 : rd_sel;
      out_found_index_r <= found_val;
      out_count_r       <= p_count_r;
      out_status_r      <= p_status_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_value  = out_read_value_r;
  assign out_found_index = out_found_index_r;
  assign out_count       = out_count_r;
  assign out_status      = out_status_r;

  // Terms for the checks
  assign acc_app_ok = in_acc && (in_mode == ilt_pkg::MODE_APPEND) &&
                      (cnt_r != ilt_pkg::CNT_W'(ilt_pkg::DEPTH));
  assign acc_lookup = in_acc && ((in_mode == ilt_pkg::MODE_READ) ||
                                 (in_mode == ilt_pkg::MODE_FIND));

  // Checks
  `ILT_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= ilt_pkg::CNT_W'(ilt_pkg::DEPTH))
  `ILT_ASSERT_NEXT(a_append_grows, acc_app_ok, cnt_r == ($past(cnt_r) + ilt_pkg::CNT_W'(1)))
  `ILT_ASSERT_NEXT(a_lookup_keeps_cnt, acc_lookup, $stable(cnt_r))
  `ILT_ASSERT_NOW(a_full_at_cap, out_valid_r && (out_status_r == ilt_pkg::ST_FULL), out_count_r == ilt_pkg::CNT_W'(ilt_pkg::DEPTH))

endmodule
